### src/rzw_pkg.sv
`timescale 1ns / 1ps
package rzw_pkg;

  localparam int ZONES_PER_ROW_DEF = 8;
  localparam int SENSOR_COUNT_DEF = 3;

  localparam logic [7:0] STATUS_OK_A = 8'd5;
  localparam logic [7:0] STATUS_OK_B = 8'd9;

  localparam int FULL_TURN = 5760;
  localparam int HALF_TURN = 2880;
  localparam int QUARTER_TURN = 1440;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_XW = 33;
  localparam int CORDIC_ZW = 26;
  localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 33'sd652032874;

  localparam int ANG_W = 15;
  localparam int TRIG_W = 17;

  localparam int REG_ENABLE = 0;
  localparam int REG_RIGHT = 1;
  localparam int REG_LEFT = 2;
  localparam int REG_CENTRE = 3;
  localparam int REG_SIDE_FOV = 4;
  localparam int REG_CENTRE_FOV = 5;
  localparam int REG_MAX_RANGE = 6;

  localparam logic [1:0] SENSOR_RIGHT = 2'd0;
  localparam logic [1:0] SENSOR_LEFT = 2'd1;
  localparam logic [1:0] SENSOR_CENTRE = 2'd2;

  typedef struct packed {
    logic [1:0]         sid;
    logic [2:0]         zone;
    logic [11:0]        range;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [13:0] hd;
  } side_t;

  function automatic logic [CORDIC_ZW-1:0] step_angle(input int i);
    logic [CORDIC_ZW-1:0] a;
    case (i)
      0:       a = 26'd2949120;
      1:       a = 26'd1740967;
      2:       a = 26'd919879;
      3:       a = 26'd466945;
      4:       a = 26'd234379;
      5:       a = 26'd117304;
      6:       a = 26'd58666;
      7:       a = 26'd29335;
      8:       a = 26'd14668;
      9:       a = 26'd7334;
      10:      a = 26'd3667;
      11:      a = 26'd1833;
      12:      a = 26'd917;
      13:      a = 26'd458;
      14:      a = 26'd229;
      15:      a = 26'd115;
      default: a = 26'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [5:0] mount_fwd(input logic [1:0] sid);
    logic signed [5:0] v;
    case (sid)
      SENSOR_RIGHT:  v = 6'sd15;
      SENSOR_LEFT:   v = 6'sd15;
      SENSOR_CENTRE: v = 6'sd20;
      default:       v = 6'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [5:0] mount_lat(input logic [1:0] sid);
    logic signed [5:0] v;
    case (sid)
      SENSOR_RIGHT:  v = -6'sd20;
      SENSOR_LEFT:   v = 6'sd20;
      SENSOR_CENTRE: v = 6'sd0;
      default:       v = 6'sd0;
    endcase
    return v;
  endfunction

endpackage

### src/range_zone_to_world_point.sv
`timescale 1ns / 1ps
// Zone reading to world obstacle point.
// Input channel (in_valid/in_stall): one zone reading of a range sensor plus
// the robot pose per transaction. Readings from a disabled or unknown sensor,
// a zone beyond the row, a bad status or a range outside (0, max_range) give
// no result transaction; all others give exactly one.
// Output channel (out_valid/out_stall): obstacle x/y in mm, echoed range,
// zone angle relative to the robot front, source sensor and zone.
// One transaction can be accepted every cycle unless a stalled result holds
// the pipeline. The depth is set by the zone-angle divide by a constant
// (3 stages), the two 16-step CORDIC units (6 stages, four iterations per
// stage) and the offset multiply and sum (2 stages).
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// Registers sit on an APB port at byte address 4*index; writes take effect
// at the access cycle, pready is always high.
// Synchronous reset empties the pipeline and loads the register defaults.
module range_zone_to_world_point #(
  parameter int ZONES_PER_ROW = rzw_pkg::ZONES_PER_ROW_DEF,
  parameter int SENSOR_COUNT = rzw_pkg::SENSOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         sensor_id,
  input  logic [2:0]         zone_index,
  input  logic [7:0]         zone_status,
  input  logic [11:0]        range_mm,
  input  logic signed [15:0] robot_x,
  input  logic signed [15:0] robot_y,
  input  logic signed [13:0] robot_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] obstacle_x,
  output logic signed [15:0] obstacle_y,
  output logic [11:0]        obstacle_range,
  output logic signed [12:0] relative_angle,
  output logic [1:0]         source_sensor,
  output logic [2:0]         source_zone
);
  localparam int DEPTH = 11;
  localparam int ZA_LAT = 3;
  localparam int CO_LAT = 6;
  localparam int ZD = DEPTH - ZA_LAT;

  logic [2:0]         sensor_enable;
  logic signed [12:0] right_mount_angle, left_mount_angle, centre_mount_angle;
  logic [11:0]        side_view_width, centre_view_width;
  logic [12:0]        max_range;

  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable <= 3'd7;
      right_mount_angle <= -13'sd888;
      left_mount_angle <= 13'sd888;
      centre_mount_angle <= 13'sd0;
      side_view_width <= 12'd960;
      centre_view_width <= 12'd720;
      max_range <= 13'd500;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        3'(rzw_pkg::REG_ENABLE):     sensor_enable <= pwdata[2:0];
        3'(rzw_pkg::REG_RIGHT):      right_mount_angle <= pwdata[12:0];
        3'(rzw_pkg::REG_LEFT):       left_mount_angle <= pwdata[12:0];
        3'(rzw_pkg::REG_CENTRE):     centre_mount_angle <= pwdata[12:0];
        3'(rzw_pkg::REG_SIDE_FOV):   side_view_width <= pwdata[11:0];
        3'(rzw_pkg::REG_CENTRE_FOV): centre_view_width <= pwdata[11:0];
        3'(rzw_pkg::REG_MAX_RANGE):  max_range <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      3'(rzw_pkg::REG_ENABLE):     prdata = 32'(sensor_enable);
      3'(rzw_pkg::REG_RIGHT):      prdata = 32'({19'd0, right_mount_angle});
      3'(rzw_pkg::REG_LEFT):       prdata = 32'({19'd0, left_mount_angle});
      3'(rzw_pkg::REG_CENTRE):     prdata = 32'({19'd0, centre_mount_angle});
      3'(rzw_pkg::REG_SIDE_FOV):   prdata = 32'(side_view_width);
      3'(rzw_pkg::REG_CENTRE_FOV): prdata = 32'(centre_view_width);
      3'(rzw_pkg::REG_MAX_RANGE):  prdata = 32'(max_range);
      default:                     prdata = 32'd0;
    endcase
  end

  logic adv, ok;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    ok = (sensor_id != 2'd3) && (32'(sensor_id) < SENSOR_COUNT) &&
         sensor_enable[sensor_id] && (32'(zone_index) < ZONES_PER_ROW) &&
         ((zone_status == rzw_pkg::STATUS_OK_A) || (zone_status == rzw_pkg::STATUS_OK_B)) &&
         (range_mm != 12'd0) && ({1'b0, range_mm} < max_range);
  end

  logic signed [12:0] base;
  logic [11:0]        fov;
  always_comb begin
    case (sensor_id)
      rzw_pkg::SENSOR_RIGHT: begin
        base = right_mount_angle;
        fov = side_view_width;
      end
      rzw_pkg::SENSOR_LEFT: begin
        base = left_mount_angle;
        fov = side_view_width;
      end
      default: begin
        base = centre_mount_angle;
        fov = centre_view_width;
      end
    endcase
  end

  logic           vld [DEPTH];
  rzw_pkg::side_t side [DEPTH];
  logic signed [12:0] zang;
  logic signed [12:0] zpipe [ZD];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid && ok;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{sid: sensor_id, zone: zone_index, range: range_mm,
                   rx: robot_x, ry: robot_y, hd: robot_heading};
      for (int i = 1; i < DEPTH; i++) side[i] <= side[i-1];
      zpipe[0] <= zang;
      for (int i = 1; i < ZD; i++) zpipe[i] <= zpipe[i-1];
    end
  end

  rzw_zone_angle #(.ZONES_PER_ROW(ZONES_PER_ROW)) u_za (
    .clk(clk), .en(adv), .base(base), .fov(fov), .zone(zone_index), .zang(zang)
  );

  logic signed [rzw_pkg::ANG_W-1:0]  ang_w, ang_h;
  logic signed [rzw_pkg::TRIG_W-1:0] ch, sh, ca, sa;
  assign ang_h = rzw_pkg::ANG_W'(side[ZA_LAT-1].hd);
  assign ang_w = ang_h + rzw_pkg::ANG_W'(zang);

  rzw_cordic u_cor_h (.clk(clk), .en(adv), .ang(ang_h), .cos_q(ch), .sin_q(sh));
  rzw_cordic u_cor_w (.clk(clk), .en(adv), .ang(ang_w), .cos_q(ca), .sin_q(sa));

  localparam int PI = ZA_LAT + CO_LAT - 1;
  rzw_point u_pt (
    .clk(clk), .en(adv), .sid(side[PI].sid), .range(side[PI].range),
    .rx(side[PI].rx), .ry(side[PI].ry), .ch(ch), .sh(sh), .ca(ca), .sa(sa),
    .px(obstacle_x), .py(obstacle_y)
  );

  assign out_valid = vld[DEPTH-1];
  assign obstacle_range = side[DEPTH-1].range;
  assign source_sensor = side[DEPTH-1].sid;
  assign source_zone = side[DEPTH-1].zone;
  assign relative_angle = zpipe[ZD-1];
endmodule

### src/rzw_zone_angle.sv
`timescale 1ns / 1ps
module rzw_zone_angle #(
  parameter int ZONES_PER_ROW = rzw_pkg::ZONES_PER_ROW_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [12:0] base,
  input  logic [11:0]        fov,
  input  logic [2:0]         zone,
  output logic signed [12:0] zang
);
  localparam int SPAN = ZONES_PER_ROW - 1;
  localparam int DIV = 2 * SPAN;
  localparam int NUM_W = 22;
  localparam int U_W = 23;
  localparam int SH = 26;
  localparam int K = ((1 << 21) + DIV - 1) / DIV;
  localparam int BIAS = K * DIV;
  localparam int MUL = (1 << SH) / DIV;

  logic signed [NUM_W-1:0] num;
  logic [U_W-1:0]          u1, u2;
  logic [U_W+SH-1:0]       prod;
  logic [U_W-1:0]          q0, q;
  logic [U_W-1:0]          rem;
  logic signed [U_W:0]     qs;
  logic signed [12:0]      zang_next;

  always_comb begin
    num = NUM_W'(base) * NUM_W'(DIV) + NUM_W'($signed({1'b0, fov})) * NUM_W'(SPAN)
        - NUM_W'($signed({1'b0, zone})) * NUM_W'($signed({1'b0, fov})) * NUM_W'(2);
  end

  always_comb begin
    q0 = U_W'(prod >> SH);
    rem = u2 - U_W'(q0 * U_W'(DIV));
    q = q0 + ((rem >= U_W'(DIV)) ? U_W'(1) : U_W'(0));
    qs = $signed({1'b0, q}) - (U_W+1)'(K);
    if (qs < -(U_W+1)'(4096)) zang_next = -13'sd4096;
    else if (qs > (U_W+1)'(4095)) zang_next = 13'sd4095;
    else zang_next = 13'(qs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= U_W'($signed(num) + (U_W+1)'(SPAN) + (U_W+1)'(BIAS));
      u2 <= u1;
      prod <= (U_W+SH)'(u1) * (U_W+SH)'(MUL);
      zang <= zang_next;
    end
  end
endmodule

### src/rzw_cordic.sv
`timescale 1ns / 1ps
module rzw_cordic (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [rzw_pkg::ANG_W-1:0]      ang,
  output logic signed [rzw_pkg::TRIG_W-1:0]     cos_q,
  output logic signed [rzw_pkg::TRIG_W-1:0]     sin_q
);
  localparam int XW = rzw_pkg::CORDIC_XW;
  localparam int ZW = rzw_pkg::CORDIC_ZW;
  localparam int NSTG = rzw_pkg::CORDIC_STEPS / rzw_pkg::CORDIC_PER_STAGE;

  logic signed [XW-1:0] xs [NSTG+1];
  logic signed [XW-1:0] ys [NSTG+1];
  logic signed [ZW-1:0] zs [NSTG+1];
  logic                 fl [NSTG+1];

  logic signed [16:0] r, rf;
  logic               flip;

  always_comb begin
    r = 17'(ang);
    for (int k = -3; k <= 3; k++) begin
      if ((17'(ang) - 17'(k * rzw_pkg::FULL_TURN) >= -17'(rzw_pkg::HALF_TURN)) &&
          (17'(ang) - 17'(k * rzw_pkg::FULL_TURN) < 17'(rzw_pkg::HALF_TURN)))
        r = 17'(ang) - 17'(k * rzw_pkg::FULL_TURN);
    end
    flip = 1'b0;
    rf = r;
    if (r > 17'(rzw_pkg::QUARTER_TURN)) begin
      rf = r - 17'(rzw_pkg::HALF_TURN);
      flip = 1'b1;
    end else if (r < -17'(rzw_pkg::QUARTER_TURN)) begin
      rf = r + 17'(rzw_pkg::HALF_TURN);
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= rzw_pkg::CORDIC_X0;
      ys[0] <= '0;
      zs[0] <= ZW'(rf) <<< 12;
      fl[0] <= flip;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic signed [XW-1:0] xn, yn;
    logic signed [ZW-1:0] zn;
    always_comb begin
      logic signed [XW-1:0] dx, dy;
      xn = xs[s];
      yn = ys[s];
      zn = zs[s];
      for (int j = 0; j < rzw_pkg::CORDIC_PER_STAGE; j++) begin
        dx = yn >>> (s * rzw_pkg::CORDIC_PER_STAGE + j);
        dy = xn >>> (s * rzw_pkg::CORDIC_PER_STAGE + j);
        if (zn >= 0) begin
          xn = xn - dx;
          yn = yn + dy;
          zn = zn - $signed(rzw_pkg::step_angle(s * rzw_pkg::CORDIC_PER_STAGE + j));
        end else begin
          xn = xn + dx;
          yn = yn - dy;
          zn = zn + $signed(rzw_pkg::step_angle(s * rzw_pkg::CORDIC_PER_STAGE + j));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xs[s+1] <= xn;
        ys[s+1] <= yn;
        zs[s+1] <= zn;
        fl[s+1] <= fl[s];
      end
    end
  end

  function automatic logic signed [rzw_pkg::TRIG_W-1:0] rnd(input logic signed [XW-1:0] v,
                                                           input logic f);
    logic signed [XW-1:0] t;
    logic signed [rzw_pkg::TRIG_W-1:0] c;
    t = (v + XW'(16384)) >>> 15;
    if (t > XW'(32767)) c = 17'sd32767;
    else if (t < -XW'(32767)) c = -17'sd32767;
    else c = rzw_pkg::TRIG_W'(t);
    return f ? -c : c;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= rnd(xs[NSTG], fl[NSTG]);
      sin_q <= rnd(ys[NSTG], fl[NSTG]);
    end
  end
endmodule

### src/rzw_point.sv
`timescale 1ns / 1ps
module rzw_point (
  input  logic                              clk,
  input  logic                              en,
  input  logic [1:0]                        sid,
  input  logic [11:0]                       range,
  input  logic signed [15:0]                rx,
  input  logic signed [15:0]                ry,
  input  logic signed [rzw_pkg::TRIG_W-1:0] ch,
  input  logic signed [rzw_pkg::TRIG_W-1:0] sh,
  input  logic signed [rzw_pkg::TRIG_W-1:0] ca,
  input  logic signed [rzw_pkg::TRIG_W-1:0] sa,
  output logic signed [15:0]                px,
  output logic signed [15:0]                py
);
  localparam int SW = 34;

  logic signed [24:0] mx, my;
  logic signed [30:0] rc, rs;
  logic signed [15:0] rx1, ry1;
  logic signed [5:0]  fwd, lat;

  assign fwd = rzw_pkg::mount_fwd(sid);
  assign lat = rzw_pkg::mount_lat(sid);

  always_ff @(posedge clk) begin
    if (en) begin
      mx <= 25'(fwd) * 25'(ch) - 25'(lat) * 25'(sh);
      my <= 25'(fwd) * 25'(sh) + 25'(lat) * 25'(ch);
      rc <= 31'($signed({1'b0, range})) * 31'(ca);
      rs <= 31'($signed({1'b0, range})) * 31'(sa);
      rx1 <= rx;
      ry1 <= ry;
    end
  end

  function automatic logic signed [15:0] fin(input logic signed [15:0] p,
                                             input logic signed [24:0] m,
                                             input logic signed [30:0] r);
    logic signed [SW-1:0] t;
    t = ((SW'(p) <<< 15) + SW'(m) + SW'(r) + SW'(16384)) >>> 15;
    if (t > SW'(32767)) return 16'sh7fff;
    else if (t < -SW'(32768)) return 16'sh8000;
    else return 16'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      px <= fin(rx1, mx, rc);
      py <= fin(ry1, my, rs);
    end
  end
endmodule

### test/range_zone_to_world_point_tb.sv
`timescale 1ns / 1ps
module range_zone_to_world_point_tb;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        range;
    logic signed [12:0] angle;
    logic [1:0]         sensor;
    logic [2:0]         zone;
  } obstacle_t;

  typedef struct {
    logic [1:0]         sid;
    logic [2:0]         zone;
    logic [7:0]         status;
    logic [11:0]        range;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [13:0] hd;
    bit                 no_point;
  } reading_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam longint ARCTAN [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] sensor_id = 0;
  logic [2:0] zone_index = 0;
  logic [7:0] zone_status = 0;
  logic [11:0] range_mm = 0;
  logic signed [15:0] robot_x = 0, robot_y = 0;
  logic signed [13:0] robot_heading = 0;
  logic signed [15:0] obstacle_x, obstacle_y;
  logic [11:0] obstacle_range;
  logic signed [12:0] relative_angle;
  logic [1:0] source_sensor;
  logic [2:0] source_zone;

  logic [2:0]  cfg_enable = 3'd7;
  logic [12:0] cfg_right = -13'sd888, cfg_left = 13'd888, cfg_centre = 13'd0;
  logic [11:0] cfg_side_fov = 12'd960, cfg_centre_fov = 12'd720;
  logic [12:0] cfg_max_range = 13'd500;

  obstacle_t pending_points[$];
  int errors = 0, cycles = 0;
  int send_idle = 0, recv_idle = 0;

  range_zone_to_world_point dut (.*);

  always #10 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    flip = 0;
    r = ang % rzw_pkg::FULL_TURN;
    if (r >= rzw_pkg::HALF_TURN) r -= rzw_pkg::FULL_TURN;
    if (r < -rzw_pkg::HALF_TURN) r += rzw_pkg::FULL_TURN;
    if (r > rzw_pkg::QUARTER_TURN) begin
      r -= rzw_pkg::HALF_TURN;
      flip = 1;
    end else if (r < -rzw_pkg::QUARTER_TURN) begin
      r += rzw_pkg::HALF_TURN;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = r * 4096;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    x = clip((x + 16384) >>> 15, -32767, 32767);
    y = clip((y + 16384) >>> 15, -32767, 32767);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit locate_obstacle(input reading_t r, output obstacle_t p);
    longint base, fov, num, zang, ch, sh, ca, sa, ax, ay, fwd, lat;
    p = '{default: 0};
    if (r.sid >= rzw_pkg::SENSOR_COUNT_DEF || !cfg_enable[r.sid]) return 0;
    if (r.status != rzw_pkg::STATUS_OK_A && r.status != rzw_pkg::STATUS_OK_B) return 0;
    if (r.range == 0 || r.range >= cfg_max_range) return 0;
    case (r.sid)
      rzw_pkg::SENSOR_RIGHT: begin
        base = longint'($signed(cfg_right)); fov = longint'(cfg_side_fov);
      end
      rzw_pkg::SENSOR_LEFT: begin
        base = longint'($signed(cfg_left)); fov = longint'(cfg_side_fov);
      end
      default: begin
        base = longint'($signed(cfg_centre)); fov = longint'(cfg_centre_fov);
      end
    endcase
    num = base * 14 + fov * 7 - 2 * longint'(r.zone) * fov;
    zang = clip(floor_div(num + 7, 14), -4096, 4095);
    sin_cos(longint'(r.hd), ch, sh);
    sin_cos(longint'(r.hd) + zang, ca, sa);
    case (r.sid)
      rzw_pkg::SENSOR_RIGHT: begin fwd = 15; lat = -20; end
      rzw_pkg::SENSOR_LEFT:  begin fwd = 15; lat = 20; end
      default:               begin fwd = 20; lat = 0; end
    endcase
    ax = longint'(r.rx) * 32768 + fwd * ch - lat * sh + longint'(r.range) * ca;
    ay = longint'(r.ry) * 32768 + fwd * sh + lat * ch + longint'(r.range) * sa;
    p.x = 16'(clip((ax + 16384) >>> 15, -32768, 32767));
    p.y = 16'(clip((ay + 16384) >>> 15, -32768, 32767));
    p.range = r.range;
    p.angle = zang[12:0];
    p.sensor = r.sid;
    p.zone = r.zone;
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    obstacle_t p;
    reading_t r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    out_stall <= ($urandom % 100) < recv_idle;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected transaction, x", obstacle_x, 0);
      end else begin
        p = pending_points.pop_front();
        if (obstacle_x !== p.x) report_mismatch("obstacle_x", obstacle_x, p.x);
        if (obstacle_y !== p.y) report_mismatch("obstacle_y", obstacle_y, p.y);
        if (obstacle_range !== p.range)
          report_mismatch("obstacle_range", obstacle_range, p.range);
        if (relative_angle !== p.angle)
          report_mismatch("relative_angle", relative_angle, p.angle);
        if (source_sensor !== p.sensor)
          report_mismatch("source_sensor", source_sensor, p.sensor);
        if (source_zone !== p.zone) report_mismatch("source_zone", source_zone, p.zone);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      r = '{sensor_id, zone_index, zone_status, range_mm, robot_x, robot_y,
            robot_heading, 0};
      if (locate_obstacle(r, p)) pending_points = {pending_points, p};
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      rzw_pkg::REG_ENABLE:     cfg_enable = value[2:0];
      rzw_pkg::REG_RIGHT:      cfg_right = value[12:0];
      rzw_pkg::REG_LEFT:       cfg_left = value[12:0];
      rzw_pkg::REG_CENTRE:     cfg_centre = value[12:0];
      rzw_pkg::REG_SIDE_FOV:   cfg_side_fov = value[11:0];
      rzw_pkg::REG_CENTRE_FOV: cfg_centre_fov = value[11:0];
      default:                 cfg_max_range = value[12:0];
    endcase
  endtask

  task automatic send_reading(input reading_t r);
    while (($urandom % 100) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sensor_id <= r.sid; zone_index <= r.zone; zone_status <= r.status;
    range_mm <= r.range; robot_x <= r.rx; robot_y <= r.ry; robot_heading <= r.hd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic reading_t random_reading();
    reading_t r;
    int lim;
    lim = cfg_max_range > 4095 ? 4095 : int'(cfg_max_range);
    r.sid = ($urandom % 8 < 7) ? 2'($urandom_range(0, 2)) : 2'd3;
    r.zone = 3'($urandom);
    r.status = ($urandom % 10 < 8) ?
               (($urandom % 2) ? rzw_pkg::STATUS_OK_A : rzw_pkg::STATUS_OK_B)
             : 8'($urandom);
    r.range = ($urandom % 10 < 8) ? 12'($urandom_range(0, lim)) : 12'($urandom);
    r.rx = 16'($urandom);
    r.ry = 16'($urandom);
    r.hd = ($urandom % 10 < 9) ? 14'($signed($urandom_range(0, 11520)) - 5760)
                                : 14'($urandom);
    r.no_point = 0;
    return r;
  endfunction

  reading_t directed[] = '{
    '{0, 0, 5, 100, 0, 0, 0, 0},
    '{1, 7, 9, 499, 32767, 32767, 5760, 0},
    '{2, 3, 5, 1, -32768, -32768, -5760, 0},
    '{0, 7, 5, 499, 100, -100, 2880, 0},
    '{1, 0, 9, 250, -200, 300, -2880, 0},
    '{2, 4, 9, 250, 1000, 1000, 8191, 0},
    '{2, 5, 5, 300, -1000, 0, -8192, 0},
    '{0, 2, 9, 400, 32767, -32768, 1440, 0},
    '{1, 6, 5, 450, -32768, 32767, -1440, 0},
    '{3, 1, 5, 100, 0, 0, 0, 1},
    '{0, 1, 4, 100, 0, 0, 0, 1},
    '{1, 1, 0, 100, 0, 0, 0, 1},
    '{2, 1, 255, 100, 0, 0, 0, 1},
    '{0, 1, 5, 0, 0, 0, 0, 1},
    '{1, 1, 9, 500, 0, 0, 0, 1},
    '{2, 1, 5, 4095, 0, 0, 0, 1}
  };

  initial begin
    obstacle_t p;
    repeat (8) @(posedge clk);
    rst <= 0;
    send_idle = 17; recv_idle = 46;
    foreach (directed[i]) begin
      if (directed[i].no_point && locate_obstacle(directed[i], p))
        report_mismatch("directed row should give no point", i, -1);
      send_reading(directed[i]);
    end
    drain();
    for (int set = 0; set < 8; set++) begin
      if (set == 3) begin send_idle = 46; recv_idle = 17; end
      if (set == 6) begin send_idle = 0; recv_idle = 0; end
      case (set)
        1: begin
          write_reg(rzw_pkg::REG_ENABLE, 5); write_reg(rzw_pkg::REG_RIGHT, -2880);
          write_reg(rzw_pkg::REG_LEFT, 2880); write_reg(rzw_pkg::REG_CENTRE, 2880);
          write_reg(rzw_pkg::REG_SIDE_FOV, 2880); write_reg(rzw_pkg::REG_CENTRE_FOV, 0);
          write_reg(rzw_pkg::REG_MAX_RANGE, 4096);
        end
        2: begin
          write_reg(rzw_pkg::REG_ENABLE, 7); write_reg(rzw_pkg::REG_MAX_RANGE, 0);
        end
        3: begin
          write_reg(rzw_pkg::REG_ENABLE, 3); write_reg(rzw_pkg::REG_RIGHT, 2880);
          write_reg(rzw_pkg::REG_LEFT, -2880); write_reg(rzw_pkg::REG_CENTRE, -2880);
          write_reg(rzw_pkg::REG_SIDE_FOV, 0); write_reg(rzw_pkg::REG_CENTRE_FOV, 2880);
          write_reg(rzw_pkg::REG_MAX_RANGE, 1);
        end
        4: begin
          write_reg(rzw_pkg::REG_ENABLE, 6); write_reg(rzw_pkg::REG_RIGHT, 32'h1FFF);
          write_reg(rzw_pkg::REG_LEFT, 32'h0FFF); write_reg(rzw_pkg::REG_CENTRE, 32'h1000);
          write_reg(rzw_pkg::REG_SIDE_FOV, 32'hFFF);
          write_reg(rzw_pkg::REG_CENTRE_FOV, 32'hFFF);
          write_reg(rzw_pkg::REG_MAX_RANGE, 32'h1FFF);
        end
        5, 6, 7: begin
          write_reg(rzw_pkg::REG_ENABLE, set == 5 ? 7 : $urandom_range(0, 7));
          write_reg(rzw_pkg::REG_RIGHT, $urandom_range(0, 5760) - 2880);
          write_reg(rzw_pkg::REG_LEFT, $urandom_range(0, 5760) - 2880);
          write_reg(rzw_pkg::REG_CENTRE, $urandom_range(0, 5760) - 2880);
          write_reg(rzw_pkg::REG_SIDE_FOV, $urandom_range(0, 2880));
          write_reg(rzw_pkg::REG_CENTRE_FOV, $urandom_range(0, 2880));
          write_reg(rzw_pkg::REG_MAX_RANGE, $urandom_range(1, 4096));
        end
        default: ;
      endcase
      repeat ((set == 2 || set == 3) ? 30 : 110) send_reading(random_reading());
      drain();
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
